// ===== hdl/swdp_pkg.sv =====
// Types and constants shared by the stack with duplicate purge.
`timescale 1ns / 1ps
package swdp_pkg;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_PURGE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [2:0] M_HOLD    = 3'd0;
    localparam logic [2:0] M_PUSH    = 3'd1;
    localparam logic [2:0] M_POP     = 3'd2;
    localparam logic [2:0] M_ROT     = 3'd3;
    localparam logic [2:0] M_COMPACT = 3'd4;

    typedef logic [2:0] t_cell_mode;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
        logic [4:0]         depth_after;
    } t_out_item;

    typedef struct packed {
        logic [31:0] data;
        logic        dead;
        logic        eff;
    } t_link;

endpackage

// ===== hdl/stack_with_duplicate_purge.sv =====
// Top level: LIFO stack of signed words as a chain of cells, with duplicate purge.
// Push, pop and unused ops: result registered in the cycle after the item is accepted;
// one item per cycle while the result is taken.
// Purge: a rotation phase (S_ROT) that marks later copies, then a compaction phase (S_CMP)
// that removes the marked entries and registers the result; no item is taken meanwhile.
// Reset (synchronous, active low) empties the stack and drops any pending result.
`timescale 1ns / 1ps
module stack_with_duplicate_purge #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  swdp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output swdp_pkg::t_out_item o_out_item
);
    import swdp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROT  = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    r_step;
    logic [CW-1:0]    n_step;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    t_cell_mode       w_mode;
    logic             w_accept;

    t_link                w_link [STACK_DEPTH];
    logic [STACK_DEPTH:0] w_prefix;
    logic [STACK_DEPTH:0] w_occ;
    logic [STACK_DEPTH-1:0] w_dead;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_prefix[0]           = 1'b0;
    assign w_occ[STACK_DEPTH]    = 1'b0;

    genvar k;
    generate
        for (k = 0; k < STACK_DEPTH; k++) begin : g_cell
            t_link w_above;
            t_link w_below;

            assign w_occ[k]  = r_count > CW'(k);
            assign w_dead[k] = w_link[k].dead;

            if (k == 0) begin : g_top
                assign w_above.data = i_in_item.push_value;
                assign w_above.dead = 1'b0;
                assign w_above.eff  = 1'b0;
            end else begin : g_mid
                assign w_above = w_link[k-1];
            end

            if (k == STACK_DEPTH - 1) begin : g_bot
                assign w_below = '0;
            end else begin : g_up
                assign w_below = w_link[k+1];
            end

            swdp_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_mode      (w_mode),
                .i_occ       (w_occ[k]),
                .i_kill_en   (k != 0),
                .i_below_occ (w_occ[k+1]),
                .i_head      (w_link[0]),
                .i_above     (w_above),
                .i_below     (w_below),
                .i_prefix    (w_prefix[k]),
                .o_link      (w_link[k]),
                .o_prefix    (w_prefix[k+1])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_mode      = M_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out.pop_value = '0;
                    n_out.status    = ST_OK;
                    n_out_valid     = 1'b1;
                    case (i_in_item.op)
                        OP_PUSH: begin
                            if (r_count == CW'(STACK_DEPTH)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_mode  = M_PUSH;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                w_mode          = M_POP;
                                n_count         = r_count - 1'b1;
                                n_out.pop_value = w_link[0].data;
                            end
                        end
                        OP_PURGE: begin
                            if (r_count != '0) begin
                                n_out_valid = 1'b0;
                                n_step      = r_count;
                                n_state     = S_ROT;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.depth_after = 5'(n_count);
                end
            end
            S_ROT: begin
                w_mode = M_ROT;
                n_step = r_step - 1'b1;
                if (r_step == CW'(1)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (w_prefix[STACK_DEPTH]) begin
                    w_mode  = M_COMPACT;
                    n_count = r_count - 1'b1;
                end else begin
                    n_out.pop_value   = '0;
                    n_out.status      = ST_OK;
                    n_out.depth_after = 5'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_step <= n_step;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("entry count above stack depth");

    a_no_marks_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_dead == '0))
        else $error("purge mark left after purge");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_item.op != OP_PURGE)) |=> o_out_valid)
        else $error("push or pop result missing");

    a_rot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (r_step != '0 && r_step <= r_count))
        else $error("rotation counter out of range");

    a_purge_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("item accepted during purge");

endmodule

// ===== hdl/swdp_cell.sv =====
// One stack cell: holds an entry and its purge mark, moves with its neighbors.
`timescale 1ns / 1ps
module swdp_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swdp_pkg::t_cell_mode i_mode,
    input  logic                 i_occ,
    input  logic                 i_kill_en,
    input  logic                 i_below_occ,
    input  swdp_pkg::t_link      i_head,
    input  swdp_pkg::t_link      i_above,
    input  swdp_pkg::t_link      i_below,
    input  logic                 i_prefix,
    output swdp_pkg::t_link      o_link,
    output logic                 o_prefix
);
    import swdp_pkg::*;

    logic [31:0] r_data;
    logic [31:0] n_data;
    logic        r_dead;
    logic        n_dead;
    logic        w_kill;

    // mark a later copy of the head value during rotation
    assign w_kill = (i_mode == M_ROT) && i_kill_en && i_occ && !i_head.dead
                    && (r_data == i_head.data);

    assign o_link.data = r_data;
    assign o_link.dead = r_dead;
    assign o_link.eff  = r_dead | w_kill;
    assign o_prefix    = i_prefix | r_dead;

    always_comb begin
        n_data = r_data;
        n_dead = r_dead;
        unique case (i_mode)
            M_PUSH: begin
                n_data = i_above.data;
            end
            M_POP: begin
                n_data = i_below.data;
            end
            M_ROT: begin
                if (i_occ) begin
                    if (i_below_occ) begin
                        n_data = i_below.data;
                        n_dead = i_below.eff;
                    end else begin
                        n_data = i_head.data;
                        n_dead = i_head.eff;
                    end
                end
            end
            M_COMPACT: begin
                if (o_prefix) begin
                    n_data = i_below.data;
                    n_dead = i_below.dead;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_dead <= 1'b0;
        end else begin
            r_dead <= n_dead;
        end
    end

endmodule
